@@ rtl/quaternion_attitude_pd_rate_limit_unit_defines.svh @@
// Assertion macros for the quaternion attitude PD rate-limit unit.
`ifndef QUATERNION_ATTITUDE_PD_RATE_LIMIT_UNIT_DEFINES_SVH
`define QUATERNION_ATTITUDE_PD_RATE_LIMIT_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define QAPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define QAPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/qapd_pkg.sv @@
// Shared types, constants and the error-quaternion term table.
package qapd_pkg;

    localparam int AXES      = 3;
    localparam int GAIN_W    = 16;
    localparam int RATE_W    = 16;
    localparam int LIM_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 5;

    // Sequencer steps: 0..15 quaternion products, 16..21 gain products,
    // 22..23 drain the multiply and accumulate stages.
    localparam logic [STEP_W-1:0] STEP_LAST_ISSUE = 5'd21;
    localparam logic [STEP_W-1:0] STEP_LAST       = 5'd23;

    localparam logic [CFG_IDX_W-1:0] REG_KP_ROLL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_PITCH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_YAW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD_ROLL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD_PITCH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_YAW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMITS = 3'd6;

    // Quaternion component indexes
    localparam logic [1:0] QC_W = 2'd0;
    localparam logic [1:0] QC_X = 2'd1;
    localparam logic [1:0] QC_Y = 2'd2;
    localparam logic [1:0] QC_Z = 2'd3;

    typedef logic [AXES-1:0][GAIN_W-1:0] t_axis_word;

    typedef struct packed {
        logic              load_in;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] est_idx;
        logic [1:0] des_idx;
        logic       neg;
    } t_qterm;

    // Terms of conj(est) * des: four components, four products each.
    function automatic t_qterm qterm(input logic [3:0] idx);
        t_qterm t;
        case (idx)
            4'd0:    t = '{QC_W, QC_W, 1'b0};
            4'd1:    t = '{QC_X, QC_X, 1'b0};
            4'd2:    t = '{QC_Y, QC_Y, 1'b0};
            4'd3:    t = '{QC_Z, QC_Z, 1'b0};
            4'd4:    t = '{QC_W, QC_X, 1'b0};
            4'd5:    t = '{QC_X, QC_W, 1'b1};
            4'd6:    t = '{QC_Y, QC_Z, 1'b1};
            4'd7:    t = '{QC_Z, QC_Y, 1'b0};
            4'd8:    t = '{QC_W, QC_Y, 1'b0};
            4'd9:    t = '{QC_X, QC_Z, 1'b0};
            4'd10:   t = '{QC_Y, QC_W, 1'b1};
            4'd11:   t = '{QC_Z, QC_X, 1'b1};
            4'd12:   t = '{QC_W, QC_Z, 1'b0};
            4'd13:   t = '{QC_X, QC_Y, 1'b1};
            4'd14:   t = '{QC_Y, QC_X, 1'b0};
            default: t = '{QC_Z, QC_W, 1'b1};
        endcase
        return t;
    endfunction

endpackage

@@ rtl/qapd_ctrl.sv @@
// Controller: handshake, step sequencer and output-valid tracking.
module qapd_ctrl
    import qapd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_step        = '0;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = (r_step <= STEP_LAST_ISSUE);
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/qapd_datapath.sv @@
// Datapath: shared multiplier, accumulator, rounding, saturation and clipping.
module qapd_datapath
    import qapd_pkg::*;
#(
    parameter int QUAT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  t_axis_word                   i_kp,
    input  t_axis_word                   i_kd,
    input  t_axis_word                   i_lim,
    input  logic signed [QUAT_WIDTH-1:0] i_des_w,
    input  logic signed [QUAT_WIDTH-1:0] i_des_x,
    input  logic signed [QUAT_WIDTH-1:0] i_des_y,
    input  logic signed [QUAT_WIDTH-1:0] i_des_z,
    input  logic signed [QUAT_WIDTH-1:0] i_est_w,
    input  logic signed [QUAT_WIDTH-1:0] i_est_x,
    input  logic signed [QUAT_WIDTH-1:0] i_est_y,
    input  logic signed [QUAT_WIDTH-1:0] i_est_z,
    output logic signed [RATE_W-1:0]     o_rate_x,
    output logic signed [RATE_W-1:0]     o_rate_y,
    output logic signed [RATE_W-1:0]     o_rate_z,
    output logic [AXES-1:0]              o_clip_mask
);

    localparam int QW    = QUAT_WIDTH;
    localparam int FRAC  = QW - 2;
    localparam int MW    = (QW + 1 > GAIN_W + 1) ? QW + 1 : GAIN_W + 1;
    localparam int PW    = 2 * MW;
    localparam int ACC_W = PW + 2;

    localparam logic signed [QW-1:0]    Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0]    Q_MIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_Q = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] RND_R = ACC_W'(1) << (FRAC - 3);
    localparam logic [RATE_W-2:0]       RATE_CAP = '1;

    logic signed [QW-1:0]     r_est [4];
    logic signed [QW-1:0]     r_des [4];
    logic signed [QW-1:0]     r_q [4];
    logic signed [QW-1:0]     r_prev [AXES];
    logic signed [PW-1:0]     r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1, r_v2;
    logic [STEP_W-1:0]        r_step1, r_step2;
    logic signed [RATE_W-1:0] r_rate [AXES];
    logic [AXES-1:0]          r_clip;
    logic signed [RATE_W-1:0] r_out_rate [AXES];
    logic [AXES-1:0]          r_out_clip;

    // Issue stage: pick multiplier operands for the current step
    t_qterm               iss_term;
    logic                 iss_is_q, iss_kd;
    logic [1:0]           iss_axis, iss_qi;
    logic [GAIN_W-1:0]    iss_gain;
    logic signed [QW:0]   iss_diff;
    logic signed [MW-1:0] op_a, op_b;

    always_comb begin
        iss_term = qterm(i_cmd.step[3:0]);
        iss_is_q = !i_cmd.step[4];
        iss_axis = i_cmd.step[2:1];
        iss_kd   = i_cmd.step[0];
        iss_qi   = iss_axis + 2'd1;
        iss_gain = iss_kd ? i_kd[iss_axis] : i_kp[iss_axis];
        iss_diff = (QW+1)'(r_q[iss_qi]) - (QW+1)'(r_prev[iss_axis]);
        if (iss_is_q) begin
            op_a = MW'(r_est[iss_term.est_idx]);
            op_b = MW'(r_des[iss_term.des_idx]);
        end else begin
            op_a = MW'($signed({1'b0, iss_gain}));
            op_b = iss_kd ? MW'(iss_diff) : MW'(r_q[iss_qi]);
        end
    end

    // Accumulate stage; the rounding offset seeds each sum
    t_qterm                  acc_term;
    logic                    acc_is_q, acc_first, acc_sub;
    logic signed [ACC_W-1:0] acc_base, acc_prod, acc_sum;

    always_comb begin
        acc_term  = qterm(r_step1[3:0]);
        acc_is_q  = !r_step1[4];
        acc_first = acc_is_q ? (r_step1[1:0] == 2'd0) : !r_step1[0];
        // negative error scalar flips the whole rate
        acc_sub   = acc_is_q ? acc_term.neg : r_q[QC_W][QW-1];
        acc_base  = acc_first ? (acc_is_q ? RND_Q : RND_R) : r_acc;
        acc_prod  = ACC_W'(r_prod);
        acc_sum   = acc_sub ? (acc_base - acc_prod) : (acc_base + acc_prod);
    end

    // Finalize stage: scale, saturate or clip the finished sum
    logic                     fin_is_q, fin_last;
    logic [1:0]               fin_comp, fin_axis;
    logic signed [ACC_W-1:0]  fin_qsh, fin_rsh, fin_l, fin_l_neg;
    logic [ACC_W-QW:0]        fin_hi;
    logic [GAIN_W-1:0]        fin_lim;
    logic signed [QW-1:0]     fin_q;
    logic signed [RATE_W-1:0] fin_rate;
    logic                     fin_clip;

    always_comb begin
        fin_is_q  = !r_step2[4];
        fin_last  = fin_is_q ? (r_step2[1:0] == 2'd3) : r_step2[0];
        fin_comp  = r_step2[3:2];
        fin_axis  = r_step2[2:1];
        fin_qsh   = r_acc >>> FRAC;
        fin_hi    = fin_qsh[ACC_W-1:QW-1];
        if ((&fin_hi) || (~|fin_hi)) begin
            fin_q = fin_qsh[QW-1:0];
        end else begin
            fin_q = fin_qsh[ACC_W-1] ? Q_MIN : Q_MAX;
        end
        fin_rsh   = r_acc >>> (FRAC - 2);
        fin_lim   = i_lim[fin_axis];
        fin_l     = ACC_W'($signed({1'b0, (fin_lim[GAIN_W-1] ? RATE_CAP
                                                             : fin_lim[GAIN_W-2:0])}));
        fin_l_neg = -fin_l;
        if (fin_rsh > fin_l) begin
            fin_rate = fin_l[RATE_W-1:0];
            fin_clip = 1'b1;
        end else if (fin_rsh < fin_l_neg) begin
            fin_rate = fin_l_neg[RATE_W-1:0];
            fin_clip = 1'b1;
        end else begin
            fin_rate = fin_rsh[RATE_W-1:0];
            fin_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_prev[0] <= r_q[QC_X];
                r_prev[1] <= r_q[QC_Y];
                r_prev[2] <= r_q[QC_Z];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step1 <= i_cmd.step;
        r_step2 <= r_step1;
        if (i_cmd.load_in) begin
            r_des[QC_W] <= i_des_w;
            r_des[QC_X] <= i_des_x;
            r_des[QC_Y] <= i_des_y;
            r_des[QC_Z] <= i_des_z;
            r_est[QC_W] <= i_est_w;
            r_est[QC_X] <= i_est_x;
            r_est[QC_Y] <= i_est_y;
            r_est[QC_Z] <= i_est_z;
        end
        if (i_cmd.issue) begin
            r_prod <= op_a * op_b;
        end
        if (r_v1) begin
            r_acc <= acc_sum;
        end
        if (r_v2 && fin_last) begin
            if (fin_is_q) begin
                r_q[fin_comp] <= fin_q;
            end else begin
                r_rate[fin_axis] <= fin_rate;
                r_clip[fin_axis] <= fin_clip;
            end
        end
        if (i_cmd.out_load) begin
            r_out_rate <= r_rate;
            r_out_clip <= r_clip;
        end
    end

    assign o_rate_x    = r_out_rate[0];
    assign o_rate_y    = r_out_rate[1];
    assign o_rate_z    = r_out_rate[2];
    assign o_clip_mask = r_out_clip;

endmodule

@@ rtl/quaternion_attitude_pd_rate_limit_unit.sv @@
// Top level: configuration registers, controller and datapath of the attitude PD unit.
// The result is shown valid once the sequencer has run all its steps and the output register has taken it.
// The single shared multiplier runs 22 products per beat, so a new beat waits until the last one is done.
// Input stall stays high from acceptance until the result is loaded into the output register.
// Reset: gains to zero, rate limits to all ones, previous error to zero, no beat pending.
`include "quaternion_attitude_pd_rate_limit_unit_defines.svh"

module quaternion_attitude_pd_rate_limit_unit
    import qapd_pkg::*;
#(
    parameter int QUAT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [LIM_W-1:0]             i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [QUAT_WIDTH-1:0] i_des_w,
    input  logic signed [QUAT_WIDTH-1:0] i_des_x,
    input  logic signed [QUAT_WIDTH-1:0] i_des_y,
    input  logic signed [QUAT_WIDTH-1:0] i_des_z,
    input  logic signed [QUAT_WIDTH-1:0] i_est_w,
    input  logic signed [QUAT_WIDTH-1:0] i_est_x,
    input  logic signed [QUAT_WIDTH-1:0] i_est_y,
    input  logic signed [QUAT_WIDTH-1:0] i_est_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [RATE_W-1:0]     o_rate_x,
    output logic signed [RATE_W-1:0]     o_rate_y,
    output logic signed [RATE_W-1:0]     o_rate_z,
    output logic [AXES-1:0]              o_clip_mask
);

    t_axis_word r_kp, r_kd, r_lim;
    t_dp_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= '0;
            r_kd  <= '0;
            r_lim <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KP_ROLL:     r_kp[0] <= i_cfg_wdata[GAIN_W-1:0];
                REG_KP_PITCH:    r_kp[1] <= i_cfg_wdata[GAIN_W-1:0];
                REG_KP_YAW:      r_kp[2] <= i_cfg_wdata[GAIN_W-1:0];
                REG_KD_ROLL:     r_kd[0] <= i_cfg_wdata[GAIN_W-1:0];
                REG_KD_PITCH:    r_kd[1] <= i_cfg_wdata[GAIN_W-1:0];
                REG_KD_YAW:      r_kd[2] <= i_cfg_wdata[GAIN_W-1:0];
                REG_RATE_LIMITS: r_lim   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    qapd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    qapd_datapath #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kp        (r_kp),
        .i_kd        (r_kd),
        .i_lim       (r_lim),
        .i_des_w     (i_des_w),
        .i_des_x     (i_des_x),
        .i_des_y     (i_des_y),
        .i_des_z     (i_des_z),
        .i_est_w     (i_est_w),
        .i_est_x     (i_est_x),
        .i_est_y     (i_est_y),
        .i_est_z     (i_est_z),
        .o_rate_x    (o_rate_x),
        .o_rate_y    (o_rate_y),
        .o_rate_z    (o_rate_z),
        .o_clip_mask (o_clip_mask)
    );

    `QAPD_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy")
    `QAPD_ASSERT_NOW(a_issue_while_busy, cmd.issue, o_in_stall && !cmd.load_in, "issue when idle")
    `QAPD_ASSERT_NEXT(a_load_shows_result, cmd.out_load, o_out_valid, "loaded result not shown")
    `QAPD_ASSERT_NOW(a_valid_from_load, $rose(o_out_valid), $past(cmd.out_load), "stray valid")

endmodule

@@ tb/quaternion_attitude_pd_rate_limit_unit_test.sv @@
// Self-checking testbench for the quaternion attitude PD rate-limit unit.
`timescale 1ns / 1ps

module quaternion_attitude_pd_rate_limit_unit_test;
    import qapd_pkg::*;

    localparam int QW              = 16;
    localparam int QFRAC           = QW - 2;
    localparam int Q_ONE           = 16384;
    localparam longint RATE_MAX    = 32767;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 30;
    localparam int BEATS_PER_SET   = 71;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [QW-1:0] des_w, des_x, des_y, des_z;
        logic [QW-1:0] est_w, est_x, est_y, est_z;
    } quat_pair_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate_x, rate_y, rate_z;
        logic [AXES-1:0]   clip_mask;
    } rate_beat_t;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [LIM_W-1:0]     reg_val;
        quat_pair_t           beat;
        logic                 pinned;
        rate_beat_t           want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [LIM_W-1:0]      i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic signed [QW-1:0]  i_des_w, i_des_x, i_des_y, i_des_z;
    logic signed [QW-1:0]  i_est_w, i_est_x, i_est_y, i_est_z;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [RATE_W-1:0] o_rate_x, o_rate_y, o_rate_z;
    logic [AXES-1:0]       o_clip_mask;

    // Driven with each beat: a typed-in result that replaces the prediction.
    logic                  beat_pinned;
    rate_beat_t            beat_pin_val;

    // Predictor state and register copies
    logic [GAIN_W-1:0]     kp_gain [AXES];
    logic [GAIN_W-1:0]     kd_gain [AXES];
    logic [RATE_W-1:0]     rate_lim [AXES];
    longint                prev_err [AXES];

    rate_beat_t            pending_rates [$];
    stim_row_t             directed_rows [$];
    int                    beats_sent;
    int                    rates_seen;
    int                    fail_count;
    int                    idle_cycles;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    quaternion_attitude_pd_rate_limit_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Error quaternion component: round half up to QFRAC bits, saturate.
    function automatic longint err_comp(longint a, longint b, longint c, longint d);
        longint v;
        v = (a + b + c + d + (longint'(1) <<< (QFRAC - 1))) >>> QFRAC;
        if (v > longint'(2 ** (QW - 1) - 1))
            v = longint'(2 ** (QW - 1) - 1);
        else if (v < -longint'(2 ** (QW - 1)))
            v = -longint'(2 ** (QW - 1));
        return v;
    endfunction

    function automatic longint axis_cmd(longint kp, longint kd, longint e, longint prev,
                                        logic neg, longint lim, output logic hit);
        longint s, r, l;
        s = kp * e + kd * (e - prev);
        if (neg)
            s = -s;
        // 2*S moved from Q8.8 x Q1.14 to Q6.9
        r = (s + (longint'(1) <<< (QFRAC - 3))) >>> (QFRAC - 2);
        l = (lim > RATE_MAX) ? RATE_MAX : lim;
        hit = 1'b0;
        if (r > l) begin
            r = l;
            hit = 1'b1;
        end else if (r < -l) begin
            r = -l;
            hit = 1'b1;
        end
        return r;
    endfunction

    function automatic rate_beat_t pd_rate_command(quat_pair_t qp);
        longint dw, dx, dy, dz, ew, ex, ey, ez, qw, r;
        longint err [AXES];
        logic [RATE_W-1:0] rv [AXES];
        logic [AXES-1:0] mask;
        logic hit, neg;
        rate_beat_t res;
        dw = $signed(qp.des_w);
        dx = $signed(qp.des_x);
        dy = $signed(qp.des_y);
        dz = $signed(qp.des_z);
        ew = $signed(qp.est_w);
        ex = $signed(qp.est_x);
        ey = $signed(qp.est_y);
        ez = $signed(qp.est_z);
        qw     = err_comp(ew * dw, ex * dx, ey * dy, ez * dz);
        err[0] = err_comp(ew * dx, -(ex * dw), -(ey * dz), ez * dy);
        err[1] = err_comp(ew * dy, ex * dz, -(ey * dw), -(ez * dx));
        err[2] = err_comp(ew * dz, -(ex * dy), ey * dx, -(ez * dw));
        neg = (qw < 0);
        mask = '0;
        for (int a = 0; a < AXES; a++) begin
            r = axis_cmd(kp_gain[a], kd_gain[a], err[a], prev_err[a], neg, rate_lim[a], hit);
            rv[a] = RATE_W'(r);
            mask[a] = hit;
            prev_err[a] = err[a];
        end
        res.rate_x = rv[0];
        res.rate_y = rv[1];
        res.rate_z = rv[2];
        res.clip_mask = mask;
        return res;
    endfunction

    function automatic quat_pair_t qpair(int dw, int dx, int dy, int dz,
                                         int ew, int ex, int ey, int ez);
        return {dw[QW-1:0], dx[QW-1:0], dy[QW-1:0], dz[QW-1:0],
                ew[QW-1:0], ex[QW-1:0], ey[QW-1:0], ez[QW-1:0]};
    endfunction

    function automatic rate_beat_t rates(int x, int y, int z, int m);
        return {x[RATE_W-1:0], y[RATE_W-1:0], z[RATE_W-1:0], m[AXES-1:0]};
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_beat(quat_pair_t qp);
        stim_row_t row;
        row = '0;
        row.beat = qp;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pinned(quat_pair_t qp, rate_beat_t want);
        stim_row_t row;
        row = '0;
        row.beat = qp;
        row.pinned = 1'b1;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [QW-1:0] unit_range();
        return QW'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
    endfunction

    function automatic logic [QW-1:0] corner_val();
        case ($urandom_range(6))
            0:       return 16'h8000;
            1:       return QW'(-Q_ONE);
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return QW'(Q_ONE);
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic quat_pair_t random_pair();
        logic [QW-1:0] c [8];
        int pick;
        pick = $urandom_range(99);
        for (int k = 0; k < 8; k++) begin
            if (pick < 40)
                c[k] = unit_range();
            else if (pick < 65)
                c[k] = (k < 4) ? unit_range()
                               : c[k-4] + QW'(int'($urandom_range(0, 1200)) - 600);
            else if (pick < 85)
                c[k] = QW'($urandom());
            else
                c[k] = corner_val();
        end
        return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return GAIN_W'($urandom_range(0, 1023));
            default:    return GAIN_W'($urandom());
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] random_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4, 5, 6: return RATE_W'($urandom_range(0, 2047));
            default: return RATE_W'($urandom());
        endcase
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_KP_ROLL:  kp_gain[0] = val[15:0];
            REG_KP_PITCH: kp_gain[1] = val[15:0];
            REG_KP_YAW:   kp_gain[2] = val[15:0];
            REG_KD_ROLL:  kd_gain[0] = val[15:0];
            REG_KD_PITCH: kd_gain[1] = val[15:0];
            REG_KD_YAW:   kd_gain[2] = val[15:0];
            REG_RATE_LIMITS: begin
                rate_lim[0] = val[15:0];
                rate_lim[1] = val[31:16];
                rate_lim[2] = val[47:32];
            end
            default: ;
        endcase
    endtask

    task automatic load_random_config();
        write_reg(REG_KP_ROLL,  {$urandom(), random_gain()});
        write_reg(REG_KP_PITCH, {$urandom(), random_gain()});
        write_reg(REG_KP_YAW,   {$urandom(), random_gain()});
        write_reg(REG_KD_ROLL,  {$urandom(), random_gain()});
        write_reg(REG_KD_PITCH, {$urandom(), random_gain()});
        write_reg(REG_KD_YAW,   {$urandom(), random_gain()});
        write_reg(REG_RATE_LIMITS, {random_limit(), random_limit(), random_limit()});
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, {random_gain(), $urandom()});
    endtask

    task automatic send_beat(quat_pair_t qp, logic pin, rate_beat_t want);
        // drop any write strobe left from a config burst
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        {i_des_w, i_des_x, i_des_y, i_des_z, i_est_w, i_est_x, i_est_y, i_est_z} <= qp;
        beat_pinned  <= pin;
        beat_pin_val <= want;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_rates_drained();
        i_in_valid <= 1'b0;
        while (rates_seen != beats_sent)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : scoreboard
        quat_pair_t taken;
        rate_beat_t predicted, got, oldest;
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                taken = {i_des_w, i_des_x, i_des_y, i_des_z,
                         i_est_w, i_est_x, i_est_y, i_est_z};
                predicted = pd_rate_command(taken);
                pending_rates.push_back(beat_pinned ? beat_pin_val : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                rates_seen++;
                got = {o_rate_x, o_rate_y, o_rate_z, o_clip_mask};
                if (pending_rates.size() == 0) begin
                    $error("rate beat with no expectation waiting");
                    fail_count++;
                end else begin
                    oldest = pending_rates.pop_front();
                    check_field("rate_x", $signed(oldest.rate_x), $signed(got.rate_x));
                    check_field("rate_y", $signed(oldest.rate_y), $signed(got.rate_y));
                    check_field("rate_z", $signed(oldest.rate_z), $signed(got.rate_z));
                    check_field("clip_mask", int'(oldest.clip_mask), int'(got.clip_mask));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("quaternion_attitude_pd_rate_limit_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        for (int a = 0; a < AXES; a++) begin
            kp_gain[a]  = '0;
            kd_gain[a]  = '0;
            rate_lim[a] = '1;
            prev_err[a] = 0;
        end
        beats_sent    = 0;
        rates_seen    = 0;
        fail_count    = 0;
        idle_cycles   = 0;
        send_idle_pct = 36;
        recv_idle_pct = 66;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_KP_ROLL;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        {i_des_w, i_des_x, i_des_y, i_des_z, i_est_w, i_est_x, i_est_y, i_est_z} = '0;
        beat_pinned   = 1'b0;
        beat_pin_val  = '0;

        // Reset config: zero gains give zero rates whatever the attitude.
        add_pinned(qpair(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0), rates(0, 0, 0, 0));
        add_pinned(qpair(Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE),
                   rates(0, 0, 0, 0));
        add_pinned(qpair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767),
                   rates(0, 0, 0, 0));
        // Full-scale x error with maximum gain saturates at 16 bits.
        add_write(REG_KP_ROLL, 48'hFFFF);
        add_pinned(qpair(0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0), rates(32767, 0, 0, 1));
        add_pinned(qpair(0, -Q_ONE, 0, 0, Q_ONE, 0, 0, 0), rates(-32767, 0, 0, 1));
        // Zero limit: nonzero rate clips to zero, zero rate does not flag.
        add_write(REG_RATE_LIMITS, '0);
        add_pinned(qpair(0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0), rates(0, 0, 0, 1));
        add_pinned(qpair(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0), rates(0, 0, 0, 0));
        add_write(REG_KP_ROLL, 48'h0180);
        add_write(REG_KP_PITCH, 48'h0100);
        add_write(REG_KP_YAW, 48'h0200);
        add_write(REG_KD_ROLL, 48'h0040);
        add_write(REG_KD_PITCH, 48'hFFFF);
        add_write(REG_KD_YAW, 48'h0100);
        add_write(REG_RATE_LIMITS, {16'h8000, 16'd1500, 16'd600});
        // Negative scalar part flips the whole vector, D term included.
        add_beat(qpair(-Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0));
        add_beat(qpair(-11585, 11585, 0, 0, Q_ONE, 0, 0, 0));
        add_beat(qpair(-11585, 0, -11585, 0, Q_ONE, 0, 0, 0));
        add_beat(qpair(-11585, 0, 0, 11585, Q_ONE, 0, 0, 0));
        add_beat(qpair(8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192));
        // Non-unit and out-of-range quaternions; the full-scale ones saturate the error.
        add_beat(qpair(32767, 32767, 32767, 32767, 32767, -32768, 32767, -32768));
        add_beat(qpair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        add_beat(qpair(0, 0, 0, 0, 0, 0, 0, 0));
        add_beat(qpair(1, -1, 1, -1, -1, 1, -1, 1));
        add_write(REG_UNUSED, '1);
        add_beat(qpair(16000, 2000, -3000, 1000, 16300, -500, 700, -200));
        add_write(REG_RATE_LIMITS, '1);
        add_write(REG_KP_ROLL, 48'hFFFF);
        add_write(REG_KP_PITCH, 48'hFFFF);
        add_write(REG_KP_YAW, 48'hFFFF);
        add_write(REG_KD_ROLL, 48'hFFFF);
        add_write(REG_KD_PITCH, 48'hFFFF);
        add_write(REG_KD_YAW, 48'hFFFF);
        add_beat(qpair(0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
        add_beat(qpair(-Q_ONE, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
        add_beat(qpair(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_write) begin
                wait_rates_drained();
                write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
            end else begin
                send_beat(directed_rows[n].beat, directed_rows[n].pinned,
                          directed_rows[n].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 36 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                // hold off the sender until the pipe is empty, then retune
                wait_rates_drained();
                load_random_config();
                repeat (BEATS_PER_SET)
                    send_beat(random_pair(), 1'b0, '0);
            end
        end

        wait_rates_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_rates.size() != 0) begin
            $error("%0d expected rate beats never arrived", pending_rates.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("quaternion_attitude_pd_rate_limit_unit: match");
        else
            $display("quaternion_attitude_pd_rate_limit_unit: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/qapd_pkg.sv
rtl/qapd_ctrl.sv
rtl/qapd_datapath.sv
rtl/quaternion_attitude_pd_rate_limit_unit.sv
tb/quaternion_attitude_pd_rate_limit_unit_test.sv
